/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/lbid_pkg.sv */
// Types, constants and the check-value function of the LED ID receiver.
`default_nettype none

package lbid_pkg;

  typedef enum logic [1:0] {
    STATUS_BUSY  = 2'd0,
    STATUS_FOUND = 2'd1,
    STATUS_END   = 2'd2
  } lbid_status_e;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  localparam logic [1:0] REG_ON_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_BIT_PERIOD   = 2'd1;
  localparam logic [1:0] REG_FRAME_PERIOD = 2'd2;
  localparam logic [1:0] REG_TIME_MARGIN  = 2'd3;

  localparam logic [15:0] ON_THRESHOLD_RST = 16'd100;
  localparam logic [15:0] BIT_PERIOD_RST   = 16'd200;
  localparam logic [15:0] FRAME_PERIOD_RST = 16'd33;
  localparam logic [9:0]  TIME_MARGIN_RST  = 10'd10;

  localparam int unsigned FRAME_MARK_BIT = 20;
  localparam logic [2:0]  ONES_NEEDED    = 3'd3;
  localparam logic [2:0]  ONES_SAT       = 3'd4;

  // Remainder of x^i modulo x^4+x^2+x+1 for each data bit i.
  localparam logic [3:0] CHECK_REM [16] = '{
    4'h1, 4'h2, 4'h4, 4'h8, 4'h7, 4'hE, 4'hB, 4'h1,
    4'h2, 4'h4, 4'h8, 4'h7, 4'hE, 4'hB, 4'h1, 4'h2
  };

  typedef struct packed {
    logic [15:0] on_threshold;
    logic [15:0] bit_period;
    logic [15:0] frame_period;
    logic [9:0]  time_margin;
  } lbid_cfg_t;

  typedef struct packed {
    logic [15:0] found_code;
    logic [31:0] shift_bits;
    logic [31:0] bit_start_time;
    logic [31:0] level_start_time;
    logic        last_level;
    logic        first_frame;
    logic [2:0]  on_frames;
  } lbid_state_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] lit_count;
    logic [31:0] stamp;
  } lbid_item_t;

  typedef struct packed {
    lbid_status_e status;
    logic [15:0]  led_code;
  } lbid_result_t;

  // The check value is linear in the data, so it is an XOR of per-bit terms.
  function automatic logic [3:0] check_rem(input logic [15:0] data);
    logic [3:0] rem;
    rem = 4'h0;
    for (int i = 0; i < 16; i++) begin
      if (data[i]) begin
        rem = rem ^ CHECK_REM[i];
      end
    end
    return rem;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lbid_decode.sv */
// Per-frame decode step: next session state and result from one item.
`default_nettype none

module lbid_decode (
  input  lbid_pkg::lbid_cfg_t    cfg_i,
  input  lbid_pkg::lbid_state_t  state_i,
  input  lbid_pkg::lbid_item_t   item_i,
  output lbid_pkg::lbid_state_t  state_o,
  output lbid_pkg::lbid_result_t result_o
);
  import lbid_pkg::*;

  always_comb begin
    logic        level;
    logic        flip;
    logic [17:0] lim_long;
    logic [17:0] lim_short;
    logic [16:0] two_frames;
    logic [16:0] half_frame;
    logic [31:0] since_bit;
    logic [31:0] since_level;
    logic        bit_end;
    logic        state_end;
    logic        quick_end;
    logic        is_data;
    logic [31:0] shift_n;
    logic [15:0] data;

    level       = item_i.lit_count > cfg_i.on_threshold;
    flip        = state_i.last_level != level;
    two_frames  = {cfg_i.frame_period, 1'b0};
    lim_long    = {2'b00, cfg_i.bit_period} + {1'b0, two_frames} + {8'h00, cfg_i.time_margin};
    lim_short   = {2'b00, cfg_i.bit_period} + {2'b00, cfg_i.frame_period}
                + {8'h00, cfg_i.time_margin};
    half_frame  = {2'b00, cfg_i.bit_period[15:1]} + {1'b0, cfg_i.frame_period};
    since_bit   = item_i.stamp - state_i.bit_start_time;
    since_level = item_i.stamp - state_i.level_start_time;
    bit_end     = since_bit > {14'h0, lim_long};
    state_end   = state_i.last_level ? (since_level > {14'h0, lim_long})
                                     : (since_level > {14'h0, lim_short});
    quick_end   = (two_frames > {7'h00, cfg_i.time_margin}) &&
                  (since_level < {15'h0, two_frames - {7'h00, cfg_i.time_margin}});
    is_data     = level ? (since_bit > {17'h0, cfg_i.bit_period[15:1]})
                        : (since_bit > {15'h0, half_frame});
    shift_n     = state_i.shift_bits;
    data        = 16'h0;

    state_o  = state_i;
    result_o = '{status: STATUS_BUSY, led_code: 16'h0};

    if (item_i.req_type == REQ_START) begin
      state_o.found_code       = 16'h0;
      state_o.shift_bits       = 32'h0;
      state_o.on_frames        = 3'd1;
      state_o.last_level       = 1'b0;
      state_o.first_frame      = 1'b1;
      state_o.bit_start_time   = item_i.stamp;
      state_o.level_start_time = item_i.stamp;
    end else if (state_i.found_code != 16'h0) begin
      result_o.status   = STATUS_FOUND;
      result_o.led_code = state_i.found_code;
    end else begin
      if (flip) begin
        if (!state_end && state_i.last_level) begin
          state_end = quick_end;
        end
        state_o.level_start_time = item_i.stamp;
      end
      state_end = state_end && (state_i.on_frames > ONES_NEEDED);
      if ((!flip && bit_end) || state_end) begin
        result_o.status = STATUS_END;
      end

      if (!state_i.first_frame && (flip || bit_end)) begin
        if (state_i.shift_bits == 32'h0 || is_data) begin
          shift_n                = {state_i.shift_bits[30:0], ~level};
          state_o.bit_start_time = item_i.stamp;
        end
      end
      state_o.shift_bits = shift_n;

      if (level && state_i.on_frames < ONES_SAT) begin
        state_o.on_frames = state_i.on_frames + 3'd1;
      end

      if (shift_n[FRAME_MARK_BIT]) begin
        data = shift_n[19:4];
        if (data != 16'h0 && check_rem(data) == shift_n[3:0]) begin
          state_o.found_code = data;
          result_o.status    = STATUS_FOUND;
        end
      end

      state_o.last_level  = level;
      state_o.first_frame = 1'b0;
      result_o.led_code   = state_o.found_code;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/led_blink_id_receiver.sv */
// Throughput: one beat per cycle while the result beat is not held back by
// m_axis_tready; the input register feeds one decode step into the result
// register, and the session state is updated in that step.
// Reset clears the session state, both valid flags and loads the register
// defaults (threshold 100, bit period 200, frame period 33, margin 10).
// Top level of the blinking LED ID receiver.
`default_nettype none

module led_blink_id_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // lit_count [15:0], stamp [47:16]
  input  wire logic        s_axis_tuser,  // req_type
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,  // led_code
  output      logic [1:0]  m_axis_tuser   // status
);
  import lbid_pkg::*;

  lbid_cfg_t    cfg_q;
  lbid_state_t  state_q;
  lbid_state_t  state_d;
  lbid_item_t   item_q;
  logic         in_valid_q;
  lbid_result_t result_q;
  lbid_result_t result_d;
  logic         out_valid_q;
  logic         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{on_threshold: ON_THRESHOLD_RST, bit_period: BIT_PERIOD_RST,
                 frame_period: FRAME_PERIOD_RST, time_margin: TIME_MARGIN_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ON_THRESHOLD: cfg_q.on_threshold <= cfg_wdata_i;
        REG_BIT_PERIOD:   cfg_q.bit_period   <= cfg_wdata_i;
        REG_FRAME_PERIOD: cfg_q.frame_period <= cfg_wdata_i;
        REG_TIME_MARGIN:  cfg_q.time_margin  <= cfg_wdata_i[9:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= '{req_type: s_axis_tuser, lit_count: s_axis_tdata[15:0],
                  stamp: s_axis_tdata[47:16]};
    end
  end

  lbid_decode u_decode (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{found_code: 16'h0, shift_bits: 32'h0, bit_start_time: 32'h0,
                   level_start_time: 32'h0, last_level: 1'b0, first_frame: 1'b1,
                   on_frames: 3'd1};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q.led_code;
  assign m_axis_tuser  = result_q.status;

endmodule

`default_nettype wire

/* hw/rtl/lbid_checker.sv */
// Port-level checks of the LED ID receiver and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module lbid_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  import lbid_pkg::*;

  logic        out_wait;
  logic        found_beat;
  logic        status_ok;
  logic [17:0] out_beat;

  assign out_wait   = m_axis_tvalid && !m_axis_tready;
  assign found_beat = m_axis_tvalid && (m_axis_tuser == STATUS_FOUND);
  assign status_ok  = (m_axis_tuser == STATUS_BUSY) || (m_axis_tuser == STATUS_FOUND)
                   || (m_axis_tuser == STATUS_END);
  assign out_beat   = {m_axis_tuser, m_axis_tdata};

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(out_beat))
  `ASSERT_IMPLY(a_status_known, clk_i, rst_ni, m_axis_tvalid, status_ok)
  `ASSERT_IMPLY(a_found_nonzero, clk_i, rst_ni, found_beat, m_axis_tdata != 16'h0)
  `ASSERT_IMPLY(a_unfound_zero, clk_i, rst_ni, m_axis_tvalid && !found_beat, m_axis_tdata == 16'h0)

endmodule

bind led_blink_id_receiver lbid_checker u_lbid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
